/* rtl/pss_pkg.sv */
// ----------------------------------------------------------------------------
// pss_pkg : shared constants and types of the periodic 11-tap stencil
// Tap geometry, register map, fixed-point widths and the result tag that
// travels beside the arithmetic pipeline.
// ----------------------------------------------------------------------------
package pss_pkg;

  localparam int TAPS        = 11;
  localparam int HEAD        = 10;
  localparam int HALF_TAPS   = 5;
  localparam int NCOEF       = 6;
  localparam int COEF_W      = 18;
  localparam int LEN_W       = 11;
  localparam int POS_W       = 10;
  localparam int CFG_DATA_W  = 18;
  localparam int CFG_INDEX_W = 3;
  localparam int ROUND_SHIFT = 17;
  localparam int FIFO_DEPTH  = 8;
  localparam int LEN_RESET   = 1024;

  localparam int DEF_MAX_LINE     = 1024;
  localparam int DEF_SAMPLE_WIDTH = 24;

  localparam int WIN_IDX_W  = $clog2(TAPS);
  localparam int HEAD_IDX_W = $clog2(HEAD);
  localparam int BURST_W    = $clog2(HEAD + 1);

  localparam logic signed [COEF_W-1:0] COEF_CENTER_RESET = 18'sd65536;
  localparam logic signed [COEF_W-1:0] COEF_SIDE_RESET   = 18'sd0;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LINE_LENGTH,
    REG_COEF_CENTER,
    REG_COEF_ONE,
    REG_COEF_TWO,
    REG_COEF_THREE,
    REG_COEF_FOUR,
    REG_COEF_FIVE
  } pss_reg_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             line_done;
  } pss_tag_t;

endpackage

/* rtl/pss_stream_if.sv */
// ----------------------------------------------------------------------------
// pss_stream_if : sample and result channels of the stencil
// Valid/ready channels; a transfer happens on a rising edge with both high.
// ----------------------------------------------------------------------------
interface pss_sample_if #(
  parameter int SAMPLE_WIDTH = pss_pkg::DEF_SAMPLE_WIDTH
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface pss_result_if #(
  parameter int SAMPLE_WIDTH = pss_pkg::DEF_SAMPLE_WIDTH
);
  import pss_pkg::*;

  logic                           valid;
  logic                           ready;
  logic [POS_W-1:0]               position;
  logic signed [SAMPLE_WIDTH-1:0] filtered;
  logic                           line_done;

  modport source (output valid, output position, output filtered, output line_done,
                  input ready);
  modport sink   (input valid, input position, input filtered, input line_done,
                  output ready);
endinterface

/* rtl/pss_cell.sv */
// ----------------------------------------------------------------------------
// pss_cell : one storage cell of the sample chain
// Loads a value in parallel or takes its neighbour's value on a shift.
// ----------------------------------------------------------------------------
module pss_cell #(
  parameter int WIDTH = pss_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                    clk,
  input  logic                    shift,
  input  logic                    load,
  input  logic signed [WIDTH-1:0] load_value,
  input  logic signed [WIDTH-1:0] shift_in,
  output logic signed [WIDTH-1:0] value
);

  always_ff @(posedge clk) begin
    if (load) begin
      value <= load_value;
    end else if (shift) begin
      value <= shift_in;
    end
  end

endmodule

/* rtl/pss_mac.sv */
// ----------------------------------------------------------------------------
// pss_mac : folded tap of the symmetric stencil
// Adds the two mirrored samples, then multiplies by the tap coefficient.
// ----------------------------------------------------------------------------
module pss_mac #(
  parameter int SAMPLE_WIDTH = pss_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                                           clk,
  input  logic signed [SAMPLE_WIDTH-1:0]                 left,
  input  logic signed [SAMPLE_WIDTH-1:0]                 right,
  input  logic signed [pss_pkg::COEF_W-1:0]              coef,
  output logic signed [SAMPLE_WIDTH+pss_pkg::COEF_W:0]   product
);
  import pss_pkg::*;

  localparam int PAIR_W = SAMPLE_WIDTH + 1;

  logic signed [PAIR_W-1:0] pair;

  always_ff @(posedge clk) begin
    pair    <= PAIR_W'(left) + PAIR_W'(right);
    product <= pair * coef;
  end

endmodule

/* rtl/pss_fifo.sv */
// ----------------------------------------------------------------------------
// pss_fifo : result buffer in front of the result channel
// Memory plus a registered head; a push into an empty buffer goes straight
// to the head.
// ----------------------------------------------------------------------------
module pss_fifo #(
  parameter int SAMPLE_WIDTH = pss_pkg::DEF_SAMPLE_WIDTH,
  parameter int DEPTH        = pss_pkg::FIFO_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  pss_pkg::pss_tag_t              push_tag,
  input  logic signed [SAMPLE_WIDTH-1:0] push_data,
  pss_result_if.source                   results
);
  import pss_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  pss_tag_t                       tag_mem  [DEPTH];
  logic signed [SAMPLE_WIDTH-1:0] data_mem [DEPTH];

  logic [PTR_W-1:0]               wr_ptr;
  logic [PTR_W-1:0]               rd_ptr;
  logic [CNT_W-1:0]               fill;
  logic                           head_valid;
  pss_tag_t                       head_tag;
  logic signed [SAMPLE_WIDTH-1:0] head_data;

  logic pop;
  logic take;
  logic from_mem;
  logic bypass;
  logic mem_write;

  assign pop       = head_valid && results.ready;
  assign take      = !head_valid || pop;
  assign from_mem  = take && (fill != '0);
  assign bypass    = take && (fill == '0) && push;
  assign mem_write = push && !bypass;

  always_ff @(posedge clk) begin
    if (mem_write) begin
      tag_mem[wr_ptr]  <= push_tag;
      data_mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (from_mem) begin
      head_tag  <= tag_mem[rd_ptr];
      head_data <= data_mem[rd_ptr];
    end else if (bypass) begin
      head_tag  <= push_tag;
      head_data <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fill       <= '0;
      head_valid <= 1'b0;
    end else begin
      if (mem_write) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (from_mem) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      fill <= fill + CNT_W'(mem_write) - CNT_W'(from_mem);
      if (take) begin
        head_valid <= from_mem || bypass;
      end
    end
  end

  assign results.valid     = head_valid;
  assign results.position  = head_tag.position;
  assign results.line_done = head_tag.line_done;
  assign results.filtered  = head_data;

endmodule

/* rtl/periodic_symmetric_11tap_stencil.sv */
// ----------------------------------------------------------------------------
// periodic_symmetric_11tap_stencil : circular-boundary symmetric 11-tap filter
// Filters one periodic line sample by sample through a chain of window cells;
// the first ten samples are kept to close the line at its end.
//
//   channel   dir  handshake     payload
//   samples   in   valid/ready   sample
//   results   out  valid/ready   position, filtered, line_done
//   cfg       in   cfg_we        cfg_index, cfg_data
//
// One sample per cycle while samples.ready is high; results leave the buffer's
// registered head. The last sample of a line starts ten closing steps of the
// cell chain, during which samples.ready is low. A nine-entry result buffer
// with credit counting keeps the pipeline moving while results stall;
// samples.ready also drops when the credits run out.
// Synchronous reset clears counters and valid flags; no clearing pass.
// ----------------------------------------------------------------------------
module periodic_symmetric_11tap_stencil #(
  parameter int MAX_LINE     = pss_pkg::DEF_MAX_LINE,
  parameter int SAMPLE_WIDTH = pss_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [pss_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [pss_pkg::CFG_DATA_W-1:0]    cfg_data,
  pss_sample_if.sink                        samples,
  pss_result_if.source                      results
);
  import pss_pkg::*;

  localparam int CW        = $clog2(MAX_LINE);
  localparam int NW        = $clog2(MAX_LINE + 1);
  localparam int EW        = (LEN_W > NW) ? LEN_W : NW;
  localparam int PW        = SAMPLE_WIDTH + 1 + COEF_W;
  localparam int AW        = PW + 3;
  localparam int CREDITS   = FIFO_DEPTH + 1;
  localparam int OW        = $clog2(CREDITS + 1);
  localparam int STAGES    = 5;
  localparam int RESET_LEN = (LEN_RESET > MAX_LINE) ? MAX_LINE : LEN_RESET;

  localparam logic signed [AW-1:0] ROUND_HALF = AW'(1) <<< (ROUND_SHIFT - 1);
  localparam logic signed [AW-1:0] SAT_HI =
    {{(AW - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
  localparam logic signed [AW-1:0] SAT_LO = ~SAT_HI;

  // configuration
  logic [NW-1:0]              n_len;
  logic signed [COEF_W-1:0]   coef [NCOEF];
  logic [EW-1:0]              len_ext;
  logic [NW-1:0]              len_clamped;

  // control
  logic [CW-1:0]              count;
  logic [BURST_W-1:0]         burst_left;
  logic [CW-1:0]              burst_pos;
  logic [CW-1:0]              pos_step;
  logic [OW-1:0]              outstanding;
  logic                       room;
  logic                       bursting;
  logic                       accept;
  logic                       burst_step;
  logic                       shift;
  logic                       last;
  logic                       emit_norm;
  logic                       emit_last;
  logic                       issue;
  logic                       pop;
  pss_tag_t                   tag_in;

  // sample storage
  logic signed [SAMPLE_WIDTH-1:0] head_store [HEAD];
  logic signed [SAMPLE_WIDTH-1:0] win        [TAPS];
  logic signed [SAMPLE_WIDTH-1:0] win_after  [TAPS];
  logic signed [SAMPLE_WIDTH-1:0] tail       [HEAD];
  logic signed [SAMPLE_WIDTH-1:0] tail_load  [HEAD];
  logic signed [SAMPLE_WIDTH-1:0] feed;

  // arithmetic pipeline
  logic signed [PW-1:0]           prod  [NCOEF];
  logic signed [AW-1:0]           psum  [NCOEF/2];
  logic signed [AW-1:0]           total;
  logic signed [AW-1:0]           scaled;
  logic signed [SAMPLE_WIDTH-1:0] rounded;
  logic                           vld      [1:STAGES];
  pss_tag_t                       tag_pipe [1:STAGES];

  // ---------------------------------------------------------------- config
  always_comb begin
    len_ext = EW'(cfg_data[LEN_W-1:0]);
    if (len_ext < EW'(TAPS)) begin
      len_clamped = NW'(TAPS);
    end else if (len_ext > EW'(MAX_LINE)) begin
      len_clamped = NW'(MAX_LINE);
    end else begin
      len_clamped = NW'(len_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n_len   <= NW'(RESET_LEN);
      coef[0] <= COEF_CENTER_RESET;
      coef[1] <= COEF_SIDE_RESET;
      coef[2] <= COEF_SIDE_RESET;
      coef[3] <= COEF_SIDE_RESET;
      coef[4] <= COEF_SIDE_RESET;
      coef[5] <= COEF_SIDE_RESET;
    end else if (cfg_we) begin
      case (pss_reg_t'(cfg_index))
        REG_LINE_LENGTH: n_len   <= len_clamped;
        REG_COEF_CENTER: coef[0] <= cfg_data[COEF_W-1:0];
        REG_COEF_ONE:    coef[1] <= cfg_data[COEF_W-1:0];
        REG_COEF_TWO:    coef[2] <= cfg_data[COEF_W-1:0];
        REG_COEF_THREE:  coef[3] <= cfg_data[COEF_W-1:0];
        REG_COEF_FOUR:   coef[4] <= cfg_data[COEF_W-1:0];
        REG_COEF_FIVE:   coef[5] <= cfg_data[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------- control
  assign room          = outstanding < OW'(CREDITS);
  assign bursting      = burst_left != '0;
  assign samples.ready = !bursting && room;
  assign accept        = samples.valid && samples.ready;
  assign burst_step    = bursting && room;
  assign shift         = accept || burst_step;
  assign last          = NW'(count) >= (n_len - NW'(1));
  assign emit_norm     = accept && !last && (count >= CW'(HEAD));
  assign emit_last     = accept && last;
  assign issue         = emit_norm || emit_last || burst_step;
  assign pop           = results.valid && results.ready;
  assign pos_step      = ((NW'(burst_pos) + NW'(1)) == n_len) ? '0 : burst_pos + CW'(1);

  always_comb begin
    if (burst_step) begin
      tag_in.position  = POS_W'(pos_step);
      tag_in.line_done = burst_left == BURST_W'(1);
    end else if (emit_last) begin
      tag_in.position  = POS_W'(n_len - NW'(TAPS - HALF_TAPS));
      tag_in.line_done = 1'b0;
    end else begin
      tag_in.position  = POS_W'(count - CW'(HALF_TAPS));
      tag_in.line_done = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      burst_left  <= '0;
      outstanding <= '0;
    end else begin
      if (accept) begin
        count <= last ? '0 : count + CW'(1);
      end
      if (emit_last) begin
        burst_left <= BURST_W'(HEAD);
      end else if (burst_step) begin
        burst_left <= burst_left - BURST_W'(1);
      end
      outstanding <= outstanding + OW'(issue) - OW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (emit_last) begin
      burst_pos <= CW'(n_len - NW'(TAPS - HALF_TAPS));
    end else if (burst_step) begin
      burst_pos <= pos_step;
    end
  end

  // ---------------------------------------------------------- head store
  always_ff @(posedge clk) begin
    if (accept && (count < CW'(HEAD))) begin
      head_store[count[HEAD_IDX_W-1:0]] <= samples.sample;
    end
  end

  // closing samples of the line: the ones that follow sample n-1 cyclically
  always_comb begin
    logic [NW-1:0] off;
    off = n_len - NW'(TAPS);
    for (int q = 0; q < TAPS - 1; q++) begin
      win_after[q] = win[q + 1];
    end
    win_after[TAPS-1] = samples.sample;
    for (int j = 0; j < HEAD; j++) begin
      if (off <= NW'(j)) begin
        tail_load[j] = win_after[WIN_IDX_W'(NW'(j) - off)];
      end else begin
        tail_load[j] = head_store[j];
      end
    end
  end

  assign feed = bursting ? tail[0] : samples.sample;

  // ------------------------------------------------------------ cell chain
  for (genvar i = 0; i < TAPS; i++) begin : g_win
    logic signed [SAMPLE_WIDTH-1:0] nb;
    if (i == TAPS - 1) begin : g_end
      assign nb = feed;
    end else begin : g_mid
      assign nb = win[i + 1];
    end
    pss_cell #(.WIDTH(SAMPLE_WIDTH)) u_cell (
      .clk        (clk),
      .shift      (shift),
      .load       (1'b0),
      .load_value (nb),
      .shift_in   (nb),
      .value      (win[i])
    );
  end

  for (genvar j = 0; j < HEAD; j++) begin : g_tail
    logic signed [SAMPLE_WIDTH-1:0] nb;
    if (j == HEAD - 1) begin : g_end
      assign nb = tail[j];
    end else begin : g_mid
      assign nb = tail[j + 1];
    end
    pss_cell #(.WIDTH(SAMPLE_WIDTH)) u_cell (
      .clk        (clk),
      .shift      (burst_step),
      .load       (emit_last),
      .load_value (tail_load[j]),
      .shift_in   (nb),
      .value      (tail[j])
    );
  end

  // ------------------------------------------------------------ taps
  for (genvar d = 0; d < NCOEF; d++) begin : g_mac
    pss_mac #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_mac (
      .clk     (clk),
      .left    (win[HALF_TAPS - d]),
      .right   (win[HALF_TAPS + d]),
      .coef    (coef[d]),
      .product (prod[d])
    );
  end

  always_ff @(posedge clk) begin
    for (int m = 0; m < NCOEF / 2; m++) begin
      psum[m] <= AW'(prod[2*m]) + AW'(prod[2*m + 1]);
    end
    total <= psum[0] + psum[1] + psum[2];
  end

  // round half up, drop the fraction and the halving, then saturate
  always_comb begin
    scaled = (total + ROUND_HALF) >>> ROUND_SHIFT;
    if (scaled > SAT_HI) begin
      rounded = SAT_HI[SAMPLE_WIDTH-1:0];
    end else if (scaled < SAT_LO) begin
      rounded = SAT_LO[SAMPLE_WIDTH-1:0];
    end else begin
      rounded = scaled[SAMPLE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 1; s <= STAGES; s++) begin
        vld[s] <= 1'b0;
      end
    end else begin
      vld[1] <= issue;
      for (int s = 2; s <= STAGES; s++) begin
        vld[s] <= vld[s - 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    tag_pipe[1] <= tag_in;
    for (int s = 2; s <= STAGES; s++) begin
      tag_pipe[s] <= tag_pipe[s - 1];
    end
  end

  // ------------------------------------------------------------ output
  pss_fifo #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .DEPTH        (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (vld[STAGES]),
    .push_tag  (tag_pipe[STAGES]),
    .push_data (rounded),
    .results   (results)
  );

endmodule

/* rtl/pss_checker.sv */
// ----------------------------------------------------------------------------
// pss_checker : port-level checks of the stencil result channel
// Watches the result channel only; attached to the top level by bind.
// ----------------------------------------------------------------------------
module pss_checker #(
  parameter int SAMPLE_WIDTH = pss_pkg::DEF_SAMPLE_WIDTH
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [pss_pkg::POS_W-1:0]      position,
  input logic signed [SAMPLE_WIDTH-1:0] filtered,
  input logic                           line_done
);
  import pss_pkg::*;

  // line closes on the result for position four
  a_done_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && line_done |-> position == POS_W'(4))
    else $error("line_done on a position other than four");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before transfer");

  a_data_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      $stable(position) && $stable(filtered) && $stable(line_done))
    else $error("result payload changed while stalled");

endmodule

bind periodic_symmetric_11tap_stencil pss_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_pss_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .position  (results.position),
  .filtered  (results.filtered),
  .line_done (results.line_done)
);
